// ===== rtl/sfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sequenced packet framer/deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int SFD_MSG_LEN_BITS = 32;
	localparam int SFD_LEN_W = 24;

	localparam logic OP_TX = 1'b0;
	localparam logic OP_RX = 1'b1;

	localparam logic [1:0] KIND_TX_HEADER  = 2'd0;
	localparam logic [1:0] KIND_TX_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_RX_HEADER  = 2'd2;
	localparam logic [1:0] KIND_RX_PAYLOAD = 2'd3;

	localparam logic [SFD_LEN_W-1:0] MAX_CHUNK_RESET = '1;

	// Everything one input item produces; header bytes are expanded by sfd_emit.
	typedef struct packed {
		logic                 has_header;
		logic [SFD_LEN_W-1:0] hdr_len;
		logic [7:0]           hdr_seq;
		logic [7:0]           data;
		logic [1:0]           kind;
		logic [SFD_LEN_W-1:0] plen;
		logic [7:0]           rseq;
		logic                 mis;
		logic                 eop;
	} sfd_rec_t;

	typedef struct packed {
		logic       load;
		logic [7:0] value;
	} sfd_seq_upd_t;

endpackage
`default_nettype wire

// ===== rtl/sfd_tx.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_tx
// Transmit framer: message and chunk tracking, header generation.
// ----------------------------------------------------------------------------
module sfd_tx #(
	parameter int MESSAGE_LENGTH_BITS = sfd_pkg::SFD_MSG_LEN_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           first_of_message,
	input  wire logic [31:0]                    message_length,
	input  wire logic [sfd_pkg::SFD_LEN_W-1:0]  max_chunk,
	input  wire logic [7:0]                     seq,
	output sfd_pkg::sfd_rec_t                   rec,
	output logic                                rec_en,
	output logic                                seq_inc
);
	import sfd_pkg::*;

	localparam int MW = MESSAGE_LENGTH_BITS;

	logic [MW-1:0]        msg_rem_q;
	logic [SFD_LEN_W-1:0] chunk_rem_q;
	logic [MW-1:0]        len_sat;
	logic [MW-1:0]        msg_rem;
	logic [SFD_LEN_W-1:0] chunk_rem;
	logic [SFD_LEN_W-1:0] lim;
	logic [SFD_LEN_W-1:0] chunk_new;
	logic [SFD_LEN_W-1:0] chunk_pick;
	logic                 need_hdr;
	logic                 active;

	generate
		if (MW >= 32) begin : g_wide
			assign len_sat = MW'(message_length);
		end else begin : g_narrow
			assign len_sat = (|message_length[31:MW]) ? '1 : message_length[MW-1:0];
		end
	endgenerate

	always_comb begin
		msg_rem    = first_of_message ? len_sat : msg_rem_q;
		chunk_rem  = first_of_message ? '0 : chunk_rem_q;
		active     = (msg_rem != '0);
		need_hdr   = (chunk_rem == '0);
		lim        = (max_chunk == '0) ? SFD_LEN_W'(1) : max_chunk;
		chunk_pick = (msg_rem < MW'(lim)) ? msg_rem[SFD_LEN_W-1:0] : lim;
		chunk_new  = need_hdr ? chunk_pick : chunk_rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_rem_q   <= '0;
			chunk_rem_q <= '0;
		end else if (en) begin
			if (active) begin
				msg_rem_q   <= msg_rem - MW'(1);
				chunk_rem_q <= chunk_new - SFD_LEN_W'(1);
			end else begin
				msg_rem_q   <= msg_rem;
				chunk_rem_q <= chunk_rem;
			end
		end
	end

	always_comb begin
		rec            = '0;
		rec.has_header = need_hdr;
		rec.hdr_len    = chunk_pick;
		rec.hdr_seq    = seq;
		rec.data       = data_byte;
		rec.kind       = KIND_TX_PAYLOAD;
		rec.eop        = (chunk_new == SFD_LEN_W'(1));
	end

	assign rec_en  = en & active;
	assign seq_inc = en & active & need_hdr;

endmodule
`default_nettype wire

// ===== rtl/sfd_rx.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_rx
// Receive deframer: header parse, sequence check, payload pass-through.
// ----------------------------------------------------------------------------
module sfd_rx (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [7:0]   data_byte,
	input  wire logic [7:0]   seq,
	output sfd_pkg::sfd_rec_t rec,
	output logic              rec_en,
	output sfd_pkg::sfd_seq_upd_t seq_upd
);
	import sfd_pkg::*;

	logic [1:0]           hdr_pos_q;
	logic [SFD_LEN_W-1:0] len_q;
	logic [SFD_LEN_W-1:0] pay_rem_q;
	logic                 in_payload;
	logic                 seq_byte;

	assign in_payload = (pay_rem_q != '0);
	assign seq_byte   = !in_payload && (hdr_pos_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= '0;
			len_q     <= '0;
			pay_rem_q <= '0;
		end else if (en) begin
			if (in_payload) begin
				pay_rem_q <= pay_rem_q - SFD_LEN_W'(1);
			end else begin
				unique case (hdr_pos_q)
					2'd0: len_q <= {16'd0, data_byte};
					2'd1: len_q <= {8'd0, data_byte, len_q[7:0]};
					2'd2: len_q <= {data_byte, len_q[15:0]};
					default: pay_rem_q <= len_q;
				endcase
				hdr_pos_q <= hdr_pos_q + 2'd1;
			end
		end
	end

	always_comb begin
		rec      = '0;
		rec.data = data_byte;
		if (in_payload) begin
			rec.kind = KIND_RX_PAYLOAD;
			rec.eop  = (pay_rem_q == SFD_LEN_W'(1));
		end else begin
			rec.kind = KIND_RX_HEADER;
			rec.plen = len_q;
			rec.rseq = data_byte;
			rec.mis  = (data_byte != seq);
		end
	end

	assign rec_en        = en & (in_payload | seq_byte);
	assign seq_upd.load  = en & seq_byte;
	assign seq_upd.value = data_byte + 8'd1;

endmodule
`default_nettype wire

// ===== rtl/sfd_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_emit
// Result register: holds one item's record and plays out its results.
// ----------------------------------------------------------------------------
module sfd_emit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire sfd_pkg::sfd_rec_t             rec,
	output logic                               free,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic [1:0]                         kind,
	output logic [sfd_pkg::SFD_LEN_W-1:0]      packet_length,
	output logic [7:0]                         received_sequence,
	output logic                               sequence_mismatch,
	output logic                               end_of_packet,
	output logic                               last
);
	import sfd_pkg::*;

	localparam logic [2:0] POS_MAIN = 3'd4;

	sfd_rec_t   rec_q;
	logic       valid_q;
	logic [2:0] pos_q;
	logic       xfer;
	logic       final_res;

	assign xfer      = valid_q & out_ready;
	assign final_res = (pos_q == POS_MAIN);
	assign free      = !valid_q || (xfer && final_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= POS_MAIN;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q   <= rec.has_header ? 3'd0 : POS_MAIN;
		end else if (xfer) begin
			if (final_res) begin
				valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec;
		end
	end

	always_comb begin
		out_byte          = rec_q.data;
		kind              = KIND_TX_HEADER;
		packet_length     = '0;
		received_sequence = '0;
		sequence_mismatch = 1'b0;
		end_of_packet     = 1'b0;
		last              = 1'b0;
		unique case (pos_q)
			3'd0: out_byte = rec_q.hdr_len[7:0];
			3'd1: out_byte = rec_q.hdr_len[15:8];
			3'd2: out_byte = rec_q.hdr_len[23:16];
			3'd3: out_byte = rec_q.hdr_seq;
			default: begin
				kind              = rec_q.kind;
				packet_length     = rec_q.plen;
				received_sequence = rec_q.rseq;
				sequence_mismatch = rec_q.mis;
				end_of_packet     = rec_q.eop;
				last              = 1'b1;
			end
		endcase
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

// ===== rtl/sequenced_packet_framer_deframer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sequenced_packet_framer_deframer_top
// Length-prefixed packet framer/deframer with a shared 8-bit sequence counter.
// ----------------------------------------------------------------------------
// Each accepted byte is processed in the cycle it is accepted and its results
// land in a single result register. A byte that yields one result (payload,
// rx header summary) or none lets a new byte in every cycle as long as each
// previous result is taken. A transmit byte that opens a chunk yields four
// header bytes and the payload byte, so the input is held off while the
// result register plays them out. The sequence counter is shared: transmit
// headers and received headers may interleave freely.
// ----------------------------------------------------------------------------
module sequenced_packet_framer_deframer_top #(
	parameter int MESSAGE_LENGTH_BITS = sfd_pkg::SFD_MSG_LEN_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sfd_pkg::SFD_LEN_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          first_of_message,
	input  wire logic [31:0]                   message_length,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic [1:0]                         kind,
	output logic [sfd_pkg::SFD_LEN_W-1:0]      packet_length,
	output logic [7:0]                         received_sequence,
	output logic                               sequence_mismatch,
	output logic                               end_of_packet,
	output logic                               last
);
	import sfd_pkg::*;

	logic [SFD_LEN_W-1:0] max_chunk_q;
	logic [7:0]           seq_q;
	logic                 in_xfer;
	logic                 tx_en;
	logic                 rx_en;
	sfd_rec_t             tx_rec;
	sfd_rec_t             rx_rec;
	sfd_rec_t             rec;
	logic                 tx_rec_en;
	logic                 rx_rec_en;
	logic                 seq_inc;
	sfd_seq_upd_t         rx_seq_upd;
	logic                 emit_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = emit_free;
	assign in_xfer   = in_valid & in_ready;
	assign tx_en     = in_xfer & (op == OP_TX);
	assign rx_en     = in_xfer & (op == OP_RX);
	assign rec       = (op == OP_TX) ? tx_rec : rx_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_chunk_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (rx_seq_upd.load) begin
			seq_q <= rx_seq_upd.value;
		end else if (seq_inc) begin
			seq_q <= seq_q + 8'd1;
		end
	end

	sfd_tx #(
		.MESSAGE_LENGTH_BITS(MESSAGE_LENGTH_BITS)
	) u_tx (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (tx_en),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.message_length   (message_length),
		.max_chunk        (max_chunk_q),
		.seq              (seq_q),
		.rec              (tx_rec),
		.rec_en           (tx_rec_en),
		.seq_inc          (seq_inc)
	);

	sfd_rx u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (rx_en),
		.data_byte (data_byte),
		.seq       (seq_q),
		.rec       (rx_rec),
		.rec_en    (rx_rec_en),
		.seq_upd   (rx_seq_upd)
	);

	sfd_emit u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (tx_rec_en | rx_rec_en),
		.rec               (rec),
		.free              (emit_free),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.kind              (kind),
		.packet_length     (packet_length),
		.received_sequence (received_sequence),
		.sequence_mismatch (sequence_mismatch),
		.end_of_packet     (end_of_packet),
		.last              (last)
	);

endmodule
`default_nettype wire
